FILE: hdl/button_hold_time_tracker_defines.svh
// ----------------------------------------------------------------------------
// button_hold_time_tracker_defines
// Assertion macros used by the checker file of the button tracker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_HOLD_TIME_TRACKER_DEFINES_SVH
`define BUTTON_HOLD_TIME_TRACKER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BHT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bht assertion failed (same cycle)");

// next-cycle implication, disabled in reset
`define BHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bht assertion failed (next cycle)");

`endif

FILE: hdl/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg
// Types, codes and constants of the button hold-time tracker.
// ----------------------------------------------------------------------------
package bht_pkg;

  localparam int NUM_BUTTONS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 12;

  localparam int ACT_W     = 2;
  localparam int BTN_IN_W  = 4;
  localparam int KEY_W     = 9;
  localparam int TIME_W    = 32;
  localparam int FRAME_W   = 8;
  localparam int STAT_W    = 2;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int FLAG_W    = 3;

  // button, key_code, event_time_ms, now_ms, frame_ms = 85 bits, padded
  localparam int IN_TDATA_W = 88;
  // status, held, impulse_down, impulse_up ahead of the fraction
  localparam int OUT_HDR_W  = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_DOWN   = 2'd0,
    ACT_UP     = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STS_APPLIED   = 2'd0,
    STS_REPEAT    = 2'd1,
    STS_THIRD_KEY = 2'd2,
    STS_UNMATCHED = 2'd3
  } result_status_t;

  localparam logic [CFG_IDX_W-1:0] REG_DOWN_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_CREDIT   = 2'd1;

  localparam logic [CFG_W-1:0] DOWN_OFFSET_RST = 10'd100;
  localparam logic [CFG_W-1:0] UP_CREDIT_RST   = 10'd10;

  localparam logic [KEY_W-1:0] KEY_EMPTY  = 9'h000;
  localparam logic [KEY_W-1:0] KEY_MANUAL = 9'h1FF;

  localparam logic [FRAME_W-1:0] FRAME_MIN = 8'd1;

  // flag bit positions
  localparam int HELD_BIT     = 0;
  localparam int IMP_DOWN_BIT = 1;
  localparam int IMP_UP_BIT   = 2;

  typedef struct packed {
    logic [KEY_W-1:0]  key_a;
    logic [KEY_W-1:0]  key_b;
    logic [FLAG_W-1:0] flags;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] held_total;
  } rec_t;

  typedef struct packed {
    logic load_item;
    logic rd_en;
    logic exec;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sample_go;
    logic div_last;
  } sts_t;

endpackage

FILE: hdl/bht_ctrl.sv
// ----------------------------------------------------------------------------
// bht_ctrl
// Sequencer: accept, record read, update, optional division, result hand-off.
// ----------------------------------------------------------------------------
module bht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  bht_pkg::sts_t sts,
  output bht_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_SETUP = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.sample_go ? ST_SETUP : ST_DONE;
      end
      ST_SETUP: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

endmodule

FILE: hdl/bht_dpath.sv
// ----------------------------------------------------------------------------
// bht_dpath
// Button record memory, event update, restoring divider and result register.
// ----------------------------------------------------------------------------
module bht_dpath #(
  parameter int NUM_BUTTONS   = bht_pkg::NUM_BUTTONS_DEF,
  parameter int FRACTION_BITS = bht_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [bht_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bht_pkg::CFG_W-1:0]         cfg_data,
  // item fields
  input  logic [bht_pkg::ACT_W-1:0]         action,
  input  logic [bht_pkg::BTN_IN_W-1:0]      button,
  input  logic [bht_pkg::KEY_W-1:0]         key_code,
  input  logic [bht_pkg::TIME_W-1:0]        event_time_ms,
  input  logic [bht_pkg::TIME_W-1:0]        now_ms,
  input  logic [bht_pkg::FRAME_W-1:0]       frame_ms,
  // control
  input  bht_pkg::cmd_t                     cmd,
  output bht_pkg::sts_t                     sts,
  // result fields
  output logic [bht_pkg::STAT_W-1:0]        status,
  output logic                              held,
  output logic                              impulse_down,
  output logic                              impulse_up,
  output logic [FRACTION_BITS:0]            fraction_q12
);

  localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int CNT_W = $clog2(FRACTION_BITS + 1);
  localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // configuration registers
  logic [bht_pkg::CFG_W-1:0] down_offset, up_credit;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_offset <= bht_pkg::DOWN_OFFSET_RST;
      up_credit   <= bht_pkg::UP_CREDIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bht_pkg::REG_DOWN_OFFSET: down_offset <= cfg_data;
        bht_pkg::REG_UP_CREDIT:   up_credit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // item registers
  bht_pkg::action_t             act_q;
  logic [BTN_W-1:0]             idx_q;
  logic                         in_range_q;
  logic [bht_pkg::KEY_W-1:0]    key_q;
  logic [bht_pkg::TIME_W-1:0]   evt_q, now_q;
  logic [bht_pkg::FRAME_W-1:0]  frame_q;
  logic [8:0]                   btn_ext;

  assign btn_ext = 9'(button);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_q      <= bht_pkg::action_t'(action);
      idx_q      <= btn_ext[BTN_W-1:0];
      in_range_q <= (btn_ext < 9'(NUM_BUTTONS));
      key_q      <= key_code;
      evt_q      <= event_time_ms;
      now_q      <= now_ms;
      frame_q    <= frame_ms;
    end
  end

  // record store; an entry not yet written reads as the reset record
  bht_pkg::rec_t          mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] vld;
  bht_pkg::rec_t          rd_rec;
  logic                   rd_vld;
  logic                   apply;
  bht_pkg::rec_t          cur, nxt;

  assign apply = in_range_q && (act_q != bht_pkg::ACT_NONE);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_rec <= mem[idx_q];
    if (cmd.exec && apply) mem[idx_q] <= nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.rd_en) rd_vld <= vld[idx_q];
      if (cmd.exec && apply) vld[idx_q] <= 1'b1;
    end
  end

  // event update
  bht_pkg::result_status_t    res_st;
  logic [bht_pkg::TIME_W-1:0] ms_next, up_delta;

  always_comb begin
    cur      = rd_vld ? rd_rec : '0;
    nxt      = cur;
    res_st   = bht_pkg::STS_APPLIED;
    ms_next  = cur.held_total;
    up_delta = (evt_q != '0) ? (evt_q - cur.press_time) : bht_pkg::TIME_W'(up_credit);
    case (act_q)
      bht_pkg::ACT_DOWN: begin
        if (key_q == cur.key_a || key_q == cur.key_b) begin
          res_st = bht_pkg::STS_REPEAT;
        end else if (cur.key_a == bht_pkg::KEY_EMPTY) begin
          nxt.key_a = key_q;
        end else if (cur.key_b == bht_pkg::KEY_EMPTY) begin
          nxt.key_b = key_q;
        end else begin
          res_st = bht_pkg::STS_THIRD_KEY;
        end
        if (res_st == bht_pkg::STS_APPLIED && !cur.flags[bht_pkg::HELD_BIT]) begin
          nxt.press_time = (evt_q != '0) ? evt_q
                                         : now_q - bht_pkg::TIME_W'(down_offset);
          nxt.flags[bht_pkg::HELD_BIT]     = 1'b1;
          nxt.flags[bht_pkg::IMP_DOWN_BIT] = 1'b1;
        end
      end
      bht_pkg::ACT_UP: begin
        if (key_q == bht_pkg::KEY_MANUAL) begin
          nxt.key_a = bht_pkg::KEY_EMPTY;
          nxt.key_b = bht_pkg::KEY_EMPTY;
          nxt.flags = '0;
          nxt.flags[bht_pkg::IMP_UP_BIT] = 1'b1;
        end else begin
          if (cur.key_a == key_q) nxt.key_a = bht_pkg::KEY_EMPTY;
          else if (cur.key_b == key_q) nxt.key_b = bht_pkg::KEY_EMPTY;
          else res_st = bht_pkg::STS_UNMATCHED;
          if (res_st == bht_pkg::STS_APPLIED && nxt.key_a == bht_pkg::KEY_EMPTY &&
              nxt.key_b == bht_pkg::KEY_EMPTY && cur.flags[bht_pkg::HELD_BIT]) begin
            nxt.held_total = cur.held_total + up_delta;
            nxt.flags[bht_pkg::HELD_BIT]   = 1'b0;
            nxt.flags[bht_pkg::IMP_UP_BIT] = 1'b1;
          end
        end
      end
      bht_pkg::ACT_SAMPLE: begin
        nxt.flags = '0;
        nxt.flags[bht_pkg::HELD_BIT] = cur.flags[bht_pkg::HELD_BIT];
        nxt.held_total = '0;
        if (cur.flags[bht_pkg::HELD_BIT]) begin
          ms_next        = cur.held_total + (now_q - cur.press_time);
          nxt.press_time = now_q;
        end
      end
      default: ;
    endcase
  end

  // result fields captured at update time
  logic [bht_pkg::STAT_W-1:0] res_status_q;
  logic                       res_held_q, res_imp_d_q, res_imp_u_q, sample_q;
  logic [bht_pkg::TIME_W-1:0] ms_q;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ms_q <= ms_next;
      if (apply) begin
        res_status_q <= res_st;
        res_held_q   <= nxt.flags[bht_pkg::HELD_BIT];
        sample_q     <= (act_q == bht_pkg::ACT_SAMPLE);
        if (act_q == bht_pkg::ACT_SAMPLE) begin
          res_imp_d_q <= cur.flags[bht_pkg::IMP_DOWN_BIT];
          res_imp_u_q <= cur.flags[bht_pkg::IMP_UP_BIT];
        end else begin
          res_imp_d_q <= nxt.flags[bht_pkg::IMP_DOWN_BIT];
          res_imp_u_q <= nxt.flags[bht_pkg::IMP_UP_BIT];
        end
      end else begin
        res_status_q <= bht_pkg::STS_APPLIED;
        res_held_q   <= 1'b0;
        res_imp_d_q  <= 1'b0;
        res_imp_u_q  <= 1'b0;
        sample_q     <= 1'b0;
      end
    end
  end

  assign sts.sample_go = apply && (act_q == bht_pkg::ACT_SAMPLE);

  // restoring divider: (ms << FRACTION_BITS) / frame, one quotient bit a cycle;
  // the quotient is used only when ms < frame (else one), so the remainder fits the frame width
  logic [bht_pkg::FRAME_W-1:0] frame_eff, rem;
  logic [FRACTION_BITS-1:0]    quo;
  logic [CNT_W-1:0]            cnt;
  logic                        neg_q, clamp_q;
  logic [bht_pkg::FRAME_W:0]   rem2, rem_sub;
  logic                        ge;

  assign frame_eff = (frame_q == '0) ? bht_pkg::FRAME_MIN : frame_q;
  assign rem2      = {rem, 1'b0};
  assign rem_sub   = rem2 - {1'b0, frame_eff};
  assign ge        = (rem2 >= {1'b0, frame_eff});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_q   <= ms_q[bht_pkg::TIME_W-1];
      clamp_q <= (ms_q[bht_pkg::TIME_W-1:bht_pkg::FRAME_W] != '0) ||
                 (ms_q[bht_pkg::FRAME_W-1:0] >= frame_eff);
      rem     <= ms_q[bht_pkg::FRAME_W-1:0];
      quo     <= '0;
      cnt     <= CNT_W'(FRACTION_BITS);
    end else if (cmd.div_step) begin
      rem <= ge ? rem_sub[bht_pkg::FRAME_W-1:0] : rem2[bht_pkg::FRAME_W-1:0];
      quo <= {quo[FRACTION_BITS-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign sts.div_last = (cnt == CNT_W'(1));

  // output register
  logic [FRACTION_BITS:0] frac_sel;

  always_comb begin
    frac_sel = '0;
    if (sample_q && !neg_q) frac_sel = clamp_q ? FRAC_ONE : {1'b0, quo};
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= res_status_q;
      held         <= res_held_q;
      impulse_down <= res_imp_d_q;
      impulse_up   <= res_imp_u_q;
      fraction_q12 <= frac_sel;
    end
  end

endmodule

FILE: hdl/button_hold_time_tracker.sv
// Flow: key up/down pass READ, EXEC and DONE from accept to m_tvalid; a sample also
// passes SETUP and DIV, the divider producing one quotient bit per cycle.
// A new item is accepted only in IDLE, so the block takes no new item before the last
// one has been loaded into the result register; items are serialized.
// Reset: sync, active high; all records read as zero, config back to 100 / 10 ms.
// ----------------------------------------------------------------------------
// button_hold_time_tracker
// Per-button two-key hold tracking with held-fraction sampling.
// ----------------------------------------------------------------------------
module button_hold_time_tracker #(
  parameter int NUM_BUTTONS   = bht_pkg::NUM_BUTTONS_DEF,  // 1..256
  parameter int FRACTION_BITS = bht_pkg::FRACTION_BITS_DEF // 4..16
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [3:0] button, [12:4] key_code, [44:13] event_time_ms, [76:45] now_ms,
  // [84:77] frame_ms, rest zero
  input  logic [bht_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [1:0] action
  input  logic [bht_pkg::ACT_W-1:0]          s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] status, [2] held, [3] impulse_down, [4] impulse_up,
  // [FRACTION_BITS+5:5] fraction_q12, rest zero
  output logic [((bht_pkg::OUT_HDR_W + FRACTION_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bht_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bht_pkg::CFG_W-1:0]          cfg_data
);

  localparam int OUT_TDATA_W = ((bht_pkg::OUT_HDR_W + FRACTION_BITS + 1 + 7) / 8) * 8;

  bht_pkg::cmd_t cmd;
  bht_pkg::sts_t sts;

  logic [bht_pkg::STAT_W-1:0] status;
  logic                       held, impulse_down, impulse_up;
  logic [FRACTION_BITS:0]     fraction_q12;

  // config registers are plain flops, a write always completes
  assign cfg_ready = 1'b1;

  // Controller walks IDLE -> READ -> EXEC -> (SETUP -> DIV until the last quotient bit) -> DONE.
  // DONE waits only if the previous result has not been taken.
  bht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: item registers, record memory with valid bits, update logic,
  // bit-serial divider and the result register feeding m_tdata.
  bht_dpath #(
    .NUM_BUTTONS   (NUM_BUTTONS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (s_tuser),
    .button        (s_tdata[3:0]),
    .key_code      (s_tdata[12:4]),
    .event_time_ms (s_tdata[44:13]),
    .now_ms        (s_tdata[76:45]),
    .frame_ms      (s_tdata[84:77]),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .held          (held),
    .impulse_down  (impulse_down),
    .impulse_up    (impulse_up),
    .fraction_q12  (fraction_q12)
  );

  assign m_tdata = OUT_TDATA_W'({fraction_q12, impulse_up, impulse_down, held, status});

endmodule

FILE: hdl/bht_checker.sv
// ----------------------------------------------------------------------------
// bht_checker
// Port-level checks of the button tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_hold_time_tracker_defines.svh"

module bht_checker #(
  parameter int FRACTION_BITS = bht_pkg::FRACTION_BITS_DEF
) (
  input logic                                                        clk,
  input logic                                                        rst,
  input logic                                                        s_tvalid,
  input logic                                                        s_tready,
  input logic                                                        m_tvalid,
  input logic                                                        m_tready,
  input logic [((bht_pkg::OUT_HDR_W + FRACTION_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [FRACTION_BITS:0] frac;
  logic                   not_applied;

  assign frac        = m_tdata[FRACTION_BITS+5:5];
  assign not_applied = (m_tdata[1:0] != bht_pkg::STS_APPLIED);

  // stalled result transaction keeps its data
  `BHT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one item in flight: ready drops right after an accept
  `BHT_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)

  // fraction never exceeds one
  `BHT_ASSERT_IMPLY(a_frac_range, clk, rst, m_tvalid, frac <= FRAC_ONE)

  // rejected events (status other than applied) carry no fraction
  `BHT_ASSERT_IMPLY(a_frac_applied, clk, rst, m_tvalid && not_applied, frac == '0)

endmodule

bind button_hold_time_tracker bht_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_bht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
